### rtl/core/texture_slot_batcher_defines.svh
// ----------------------------------------------------------------------------
// Texture slot batcher assertion macros
// Shared assertion forms for the batcher RTL; the using module provides
// clk and rst.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_SLOT_BATCHER_DEFINES_SVH
`define TEXTURE_SLOT_BATCHER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define TSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tsb_pkg.sv
// ----------------------------------------------------------------------------
// Texture slot batcher package
// Sizes, opcodes, result kinds and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int MAX_QUADS  = 1024;
  localparam int SLOTS      = 16;
  localparam int TEX_W      = 16;

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int USED_W     = $clog2(SLOTS + 1);
  localparam int QCNT_W     = $clog2(MAX_QUADS + 1);
  localparam int QIDX_W     = 10;
  localparam int FLUSH_W    = 16;
  localparam int BIND_W     = 20;
  localparam int QTOT_W     = 24;

  localparam int OUT_FIELDS_W = SLOT_W + QIDX_W + QCNT_W + USED_W + FLUSH_W + BIND_W + QTOT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_SUBMIT = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_STATS  = 2'd3;

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic load;
    logic clear_batch;
    logic clear_stats;
    logic flush_emit;
    logic restart;
    logic place;
    logic last;
  } tsb_cmd_t;

  typedef struct packed {
    logic quads_full;
    logic slots_miss_full;
    logic batch_empty;
    logic out_free;
  } tsb_status_t;

endpackage

### rtl/core/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// Texture slot batcher controller
// Takes one request at a time and sequences flush, restart and placement.
// ----------------------------------------------------------------------------
module tsb_ctrl import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  op_in,
  input  tsb_status_t status,
  output tsb_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic       state;
  logic       state_next;
  logic [1:0] op;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.load   = s_tvalid && s_tready;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        case (op)
          OP_BEGIN: begin
            cmd.clear_batch = 1'b1;
            cmd.clear_stats = 1'b1;
            state_next      = ST_IDLE;
          end
          OP_STATS: begin
            cmd.clear_stats = 1'b1;
            state_next      = ST_IDLE;
          end
          OP_END: begin
            if (status.batch_empty) begin
              state_next = ST_IDLE;
            end else if (status.out_free) begin
              cmd.flush_emit = 1'b1;
              cmd.last       = 1'b1;
              state_next     = ST_IDLE;
            end
          end
          OP_SUBMIT: begin
            // A flush restarts the batch, so the next pass places the quad.
            if (status.quads_full || status.slots_miss_full) begin
              if (status.batch_empty) begin
                cmd.restart = 1'b1;
              end else if (status.out_free) begin
                cmd.flush_emit = 1'b1;
                cmd.restart    = 1'b1;
              end
            end else if (status.out_free) begin
              cmd.place  = 1'b1;
              cmd.last   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
    end
  end

endmodule

### rtl/core/tsb_datapath.sv
// ----------------------------------------------------------------------------
// Texture slot batcher datapath
// Slot table with parallel lookup, batch and statistics counters, and the
// output register.
// ----------------------------------------------------------------------------
`include "texture_slot_batcher_defines.svh"

module tsb_datapath import tsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  tsb_cmd_t              cmd,
  output tsb_status_t           status,
  input  logic [TEX_W-1:0]      tex_in,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  logic [TEX_W-1:0]   tex;
  logic [TEX_W-1:0]   slot_table [SLOTS];
  logic [USED_W-1:0]  slots_used;
  logic [QCNT_W-1:0]  quads_in_batch;
  logic [FLUSH_W-1:0] flush_counter;
  logic [BIND_W-1:0]  bind_counter;
  logic [QTOT_W-1:0]  quad_counter;
  logic [OUT_DATA_W-1:0] out_data;
  logic               out_kind;
  logic               out_last;

  logic [SLOTS-1:0]   hit;
  logic [SLOT_W-1:0]  hit_idx;
  logic               found;
  logic               miss;
  logic [SLOT_W-1:0]  place_slot;
  logic [BIND_W:0]    bind_sum;
  logic [BIND_W-1:0]  bind_next;
  logic [FLUSH_W-1:0] flush_next;
  logic [QTOT_W-1:0]  quad_next;
  logic [OUT_DATA_W-1:0] flush_data;
  logic [OUT_DATA_W-1:0] place_data;

  // Only slots below slots_used hold handles of the current batch.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = (i != 0) && (USED_W'(i) < slots_used) && (slot_table[i] == tex);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = SLOTS - 1; i > 0; i--) begin
      if (hit[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign found      = |hit;
  assign miss       = (tex != '0) && !found;
  assign place_slot = (tex == '0) ? '0 : (found ? hit_idx : slots_used[SLOT_W-1:0]);

  assign bind_sum   = {1'b0, bind_counter} + (BIND_W + 1)'(slots_used);
  assign bind_next  = bind_sum[BIND_W] ? '1 : bind_sum[BIND_W-1:0];
  assign flush_next = (flush_counter == '1) ? flush_counter : flush_counter + 1'b1;
  assign quad_next  = (quad_counter == '1) ? quad_counter : quad_counter + 1'b1;

  assign flush_data = {{OUT_PAD_W{1'b0}}, quad_counter, bind_next, flush_next,
                       slots_used, quads_in_batch, {QIDX_W{1'b0}}, {SLOT_W{1'b0}}};
  assign place_data = {{OUT_PAD_W{1'b0}}, quad_next, bind_counter, flush_counter,
                       {USED_W{1'b0}}, {QCNT_W{1'b0}}, quads_in_batch[QIDX_W-1:0],
                       place_slot};

  assign status.quads_full      = (quads_in_batch >= QCNT_W'(MAX_QUADS));
  assign status.slots_miss_full = miss && (slots_used >= USED_W'(SLOTS));
  assign status.batch_empty     = (quads_in_batch == '0);
  assign status.out_free        = !m_tvalid || m_tready;

  assign m_tdata = out_data;
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used     <= USED_W'(1);
      quads_in_batch <= '0;
      flush_counter  <= '0;
      bind_counter   <= '0;
      quad_counter   <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cmd.flush_emit || cmd.place) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.clear_stats) begin
        flush_counter <= '0;
        bind_counter  <= '0;
        quad_counter  <= '0;
      end
      if (cmd.clear_batch || cmd.restart) begin
        slots_used     <= USED_W'(1);
        quads_in_batch <= '0;
      end
      if (cmd.flush_emit) begin
        bind_counter  <= bind_next;
        flush_counter <= flush_next;
      end
      if (cmd.place) begin
        quad_counter   <= quad_next;
        quads_in_batch <= quads_in_batch + 1'b1;
        if (miss) begin
          slots_used <= slots_used + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tex <= tex_in;
    end
    if (cmd.place && miss) begin
      slot_table[slots_used[SLOT_W-1:0]] <= tex;
    end
    if (cmd.flush_emit) begin
      out_data <= flush_data;
      out_kind <= KIND_FLUSH;
      out_last <= cmd.last;
    end else if (cmd.place) begin
      out_data <= place_data;
      out_kind <= KIND_PLACE;
      out_last <= 1'b1;
    end
  end

  `TSB_ASSERT_SAME(a_emit_free, cmd.place || cmd.flush_emit, status.out_free,
                   "result written over a pending one")
  `TSB_ASSERT_NEXT(a_new_slot, cmd.place && miss,
                   slots_used == $past(slots_used) + 1'b1,
                   "new handle did not take a slot")
  `TSB_ASSERT_NEXT(a_flush_shown, cmd.flush_emit, m_tvalid && (m_tuser == KIND_FLUSH),
                   "flush result not presented")
  `TSB_ASSERT_SAME(a_batch_bound, 1'b1,
                   (quads_in_batch <= QCNT_W'(MAX_QUADS)) && (slots_used != '0) &&
                   (slots_used <= USED_W'(SLOTS)),
                   "batch counts out of range")

endmodule

### rtl/core/texture_slot_batcher.sv
// ----------------------------------------------------------------------------
// Texture slot batcher
// Sprite draw batcher: assigns texture slots to submitted quads and reports
// batch flushes with saturating draw statistics.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_*      in         tuser: opcode; tdata: texture_id
//  m_*      out        tuser: kind; tlast: last; tdata: slot .. quads_total
//
//  An accepted request is first registered; then, when no result waits, the
//  sixteen-entry slot table is looked up and the quad is placed.
//  A submit that forces a flush first emits the flush result, then places the quad.
//  Requests are taken one at a time; the output register lets the next
//  request enter while the last result is still held.
//  A stalled output holds the controller in its work state until the output
//  register frees. Reset is synchronous and empties batch and statistics.
// ----------------------------------------------------------------------------
module texture_slot_batcher import tsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TEX_W-1:0]      s_tdata,   // [15:0] texture_id
  input  logic [1:0]            s_tuser,   // [1:0] opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // slot, quad_index, batch_quads,
                                           // batch_textures, draw_calls,
                                           // texture_binds, quads_total, zeros
  output logic                  m_tuser,   // [0] kind
  output logic                  m_tlast
);

  tsb_cmd_t    cmd;
  tsb_status_t status;

  tsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op_in    (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  tsb_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .tex_in   (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
